FILE: rtl/eds_pkg.sv
// Shared types and constants for the elastic-degenerate shift-or matcher.
// Holds operation codes, vector widths and the cell control and mask request structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eds_pkg;

   localparam int VEC_W         = 64;
   localparam int POS_W         = 6;
   localparam int SYM_W         = 8;
   localparam int OP_W          = 3;
   localparam int LEN_W         = 7;
   localparam int CNT_W         = 32;
   localparam int ALPHABET_SIZE = 256;

   localparam logic [OP_W-1:0] OP_ALPHA   = 3'd0;
   localparam logic [OP_W-1:0] OP_PATTERN = 3'd1;
   localparam logic [OP_W-1:0] OP_START   = 3'd2;
   localparam logic [OP_W-1:0] OP_TEXT    = 3'd3;
   localparam logic [OP_W-1:0] OP_END_VAR = 3'd4;
   localparam logic [OP_W-1:0] OP_END_SEG = 3'd5;

   typedef struct packed {
      logic restart;
      logic text;
      logic end_var;
      logic end_seg;
   } cell_ctrl_type;

   typedef struct packed {
      logic             rd_en;
      logic             load_alpha;
      logic             load_pattern;
      logic [SYM_W-1:0] symbol;
      logic [POS_W-1:0] position;
   } mask_req_type;

endpackage

`default_nettype wire

FILE: rtl/eds_cell.sv
// One bit slice of the shift-or state: start, variant and join bits.
// Depends on eds_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module eds_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  eds_pkg::cell_ctrl_type ctrl,
   input  wire                   mask_bit,
   input  wire                   shift_in,
   input  wire                   hit_sel,
   output logic                  var_out,
   output logic                  hit
);
   import eds_pkg::*;

   logic start_ff, start_in;
   logic var_ff, var_in;
   logic join_ff, join_in;
   logic text_bit;
   logic joined;

   assign text_bit = shift_in | mask_bit;
   assign joined   = join_ff & var_ff;

   always_comb begin
      start_in = start_ff;
      var_in   = var_ff;
      join_in  = join_ff;
      if (ctrl.restart) begin
         start_in = 1'b1;
         var_in   = 1'b1;
         join_in  = 1'b1;
      end else if (ctrl.text) begin
         var_in = text_bit;
      end else if (ctrl.end_var) begin
         join_in = joined;
         var_in  = start_ff;
      end else if (ctrl.end_seg) begin
         start_in = joined;
         var_in   = joined;
         join_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         var_ff   <= 1'b1;
         join_ff  <= 1'b1;
      end else begin
         start_ff <= start_in;
         var_ff   <= var_in;
         join_ff  <= join_in;
      end
   end

   assign var_out = var_ff;
   // A zero at the selected position after a text symbol is an occurrence.
   assign hit     = ctrl.text & hit_sel & ~text_bit;

endmodule

`default_nettype wire

FILE: rtl/eds_mask_store.sv
// Mask table memory: whole-row and single-bit loads and a registered read per item.
// Depends on eds_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module eds_mask_store (
   input  wire                          clock,
   input  eds_pkg::mask_req_type        req,
   output logic [eds_pkg::VEC_W-1:0]    mask
);
   import eds_pkg::*;

   logic [VEC_W-1:0] mem [ALPHABET_SIZE];
   logic [VEC_W-1:0] rd_ff;
   logic             ok_ff;
   logic             sym_ok;

   assign sym_ok = {1'b0, req.symbol} < 9'(ALPHABET_SIZE);

   // A pattern symbol clears one bit only, so no read-modify-write is needed.
   always_ff @(posedge clock) begin
      if (req.load_alpha && sym_ok) begin
         mem[req.symbol] <= '1;
      end else if (req.load_pattern && sym_ok) begin
         mem[req.symbol][req.position] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_ff <= mem[req.symbol];
         ok_ff <= sym_ok;
      end
   end

   // Symbols outside the alphabet see an all-ones mask.
   assign mask = ok_ff ? rd_ff : '1;

endmodule

`default_nettype wire

FILE: rtl/eds_shift_or_matcher.sv
// Top level of the elastic-degenerate shift-or matcher.
// Depends on eds_pkg, eds_mask_store and eds_cell.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake        Carries
//  req_     in         valid / stall    operation, symbol, position
//  rsp_     out        valid / stall    segment_index, segment_matched
//  csr_     in         valid / ready    pattern_length
//
//  One item is taken per cycle while req_stall is low. The mask table is read
//  into a register as an item is accepted; the row of bit cells updates as the
//  item leaves stage one, which an end-of-segment item cannot do while a result
//  is blocked. Each cell shifts in its neighbour's registered variant bit.
//  Reset is synchronous: the cell vectors go to ones, counter and flag clear;
//  the mask table is not cleared and must be loaded before text is given.
//  req_stall rises only while an end-of-segment item waits behind a result
//  that has not yet been taken.
`default_nettype none

module eds_shift_or_matcher (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [eds_pkg::OP_W-1:0]      req_operation,
   input  wire  [eds_pkg::SYM_W-1:0]     req_symbol,
   input  wire  [eds_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [eds_pkg::CNT_W-1:0]     rsp_segment_index,
   output logic                          rsp_segment_matched,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire  [eds_pkg::LEN_W-1:0]     csr_data
);
   import eds_pkg::*;

   // Configuration: the pattern length register is always writable.
   logic [LEN_W-1:0] len_ff;
   logic [POS_W-1:0] hit_pos;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
      end else if (csr_valid && csr_ready) begin
         len_ff <= csr_data;
      end
   end

   // A length of zero behaves as one, and anything above the vector width as
   // the full width.
   always_comb begin
      if (len_ff == '0) begin
         hit_pos = '0;
      end else if (len_ff > LEN_W'(VEC_W)) begin
         hit_pos = POS_W'(VEC_W - 1);
      end else begin
         hit_pos = POS_W'(len_ff - LEN_W'(1));
      end
   end

   // Stage one holds the accepted item while its mask row is read.
   logic            s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0] s1_op_ff;
   logic            accept;
   logic            advance;
   logic            out_blocked;
   logic            rsp_valid_ff, rsp_valid_in;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign advance     = !(s1_valid_ff && (s1_op_ff == OP_END_SEG) && out_blocked);
   assign req_stall   = !advance;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff <= req_operation;
      end
   end

   mask_req_type     mreq;
   logic [VEC_W-1:0] mask;

   always_comb begin
      mreq.rd_en        = accept;
      mreq.load_alpha   = accept && (req_operation == OP_ALPHA);
      mreq.load_pattern = accept && (req_operation == OP_PATTERN);
      mreq.symbol       = req_symbol;
      mreq.position     = req_position;
   end

   eds_mask_store u_mask (
      .clock (clock),
      .req   (mreq),
      .mask  (mask)
   );

   // Decode the stage-one item into cell controls; loads and unknown codes
   // leave the cells alone.
   cell_ctrl_type ctrl;
   logic          fire;

   assign fire = s1_valid_ff && advance;

   always_comb begin
      ctrl = '0;
      if (fire) begin
         unique case (s1_op_ff)
            OP_START:   ctrl.restart = 1'b1;
            OP_TEXT:    ctrl.text    = 1'b1;
            OP_END_VAR: ctrl.end_var = 1'b1;
            OP_END_SEG: ctrl.end_seg = 1'b1;
            default:    ctrl = '0;
         endcase
      end
   end

   // The row of cells: each one takes the next lower cell's variant bit as the
   // shifted-in value, and the lowest cell shifts in a zero.
   logic [VEC_W-1:0] var_bits;
   logic [VEC_W-1:0] hits;

   for (genvar i = 0; i < VEC_W; i++) begin : g_cell
      logic shift_in;
      if (i == 0) begin : g_first
         assign shift_in = 1'b0;
      end else begin : g_rest
         assign shift_in = var_bits[i-1];
      end
      eds_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .mask_bit (mask[i]),
         .shift_in (shift_in),
         .hit_sel  (hit_pos == POS_W'(i)),
         .var_out  (var_bits[i]),
         .hit      (hits[i])
      );
   end

   // Segment counter and hit flag.
   logic [CNT_W-1:0] seg_count_ff, seg_count_in;
   logic             seg_hit_ff, seg_hit_in;

   always_comb begin
      seg_count_in = seg_count_ff;
      seg_hit_in   = seg_hit_ff;
      if (ctrl.restart) begin
         seg_count_in = '0;
         seg_hit_in   = 1'b0;
      end else if (ctrl.text) begin
         seg_hit_in = seg_hit_ff | (|hits);
      end else if (ctrl.end_seg) begin
         seg_count_in = seg_count_ff + CNT_W'(1);
         seg_hit_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= '0;
         seg_hit_ff   <= 1'b0;
      end else begin
         seg_count_ff <= seg_count_in;
         seg_hit_ff   <= seg_hit_in;
      end
   end

   // Output register: loaded when an end-of-segment item fires, which can only
   // happen while the slot is empty or being emptied.
   logic [CNT_W-1:0] rsp_index_ff;
   logic             rsp_matched_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.end_seg) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.end_seg) begin
         rsp_index_ff   <= seg_count_ff;
         rsp_matched_ff <= seg_hit_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_segment_index   = rsp_index_ff;
   assign rsp_segment_matched = rsp_matched_ff;

   // The input side is held only behind a blocked result.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && (s1_op_ff == OP_END_SEG) && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked end-of-segment item");

   // A fired end of segment always produces a result.
   a_seg_result : assert property (@(posedge clock) disable iff (reset)
      ctrl.end_seg |=> rsp_valid_ff)
      else $error("end of segment produced no result");

   // A taken result with nothing new behind it empties the slot.
   a_rsp_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !ctrl.end_seg) |=> !rsp_valid_ff)
      else $error("result repeated after being taken");

   // Starting the text clears the counter and the hit flag.
   a_restart : assert property (@(posedge clock) disable iff (reset)
      ctrl.restart |=> (seg_count_ff == '0) && !seg_hit_ff)
      else $error("start of text did not clear segment state");

   // Counter moves by one on each closed segment.
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (ctrl.end_seg && !ctrl.restart) |=> seg_count_ff == $past(seg_count_ff) + CNT_W'(1))
      else $error("segment counter did not advance");

endmodule

`default_nettype wire
